// ===== sv/wscs_pkg.sv =====
// Shared types and codes for the wire strip-and-cut sequencer.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package wscs_pkg;

    // Operation codes on the command channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Blade speed selections
    localparam logic [1:0] SPD_TRAVEL  = 2'd0;
    localparam logic [1:0] SPD_CUT     = 2'd1;
    localparam logic [1:0] SPD_DEFAULT = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLADE_UP      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLADE_PARTIAL = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLADE_FULL    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEAD_STRIP    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAIL_STRIP    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BODY_LENGTH   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_PER_MM  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIECES_WANTED = 3'd7;

    // Fixed field widths
    localparam int MM_BITS    = 16;
    localparam int COUNT_BITS = 16;
    localparam int STEPS_BITS = 32;

    // Sequencer phases, one-hot
    typedef enum logic [13:0] {
        PH_IDLE       = 14'b00000000000001,
        PH_HOMING     = 14'b00000000000010,
        PH_PREP       = 14'b00000000000100,
        PH_FEED_LEAD  = 14'b00000000001000,
        PH_PART_CUT_A = 14'b00000000010000,
        PH_RAISE_A    = 14'b00000000100000,
        PH_FEED_BODY  = 14'b00000001000000,
        PH_PART_CUT_B = 14'b00000010000000,
        PH_RAISE_B    = 14'b00000100000000,
        PH_FEED_TAIL  = 14'b00001000000000,
        PH_FULL_CUT   = 14'b00010000000000,
        PH_RAISE_C    = 14'b00100000000000,
        PH_CHECK      = 14'b01000000000000,
        PH_STOP       = 14'b10000000000000
    } phase_t;

endpackage

// ===== sv/wscs_if.sv =====
// Channel interfaces of the wire strip-and-cut sequencer: command, result and
// configuration write. Depends on wscs_pkg for fixed widths.
`timescale 1ns / 1ps

interface wscs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       homed;
    logic       blade_ready;
    logic       feed_ready;

    modport source (output valid, output operation, output homed, output blade_ready,
                    output feed_ready, input ready);
    modport sink   (input valid, input operation, input homed, input blade_ready,
                    input feed_ready, output ready);
endinterface

interface wscs_res_if #(parameter int POSITION_BITS = 24);
    logic                                 valid;
    logic                                 ready;
    logic                                 blade_move;
    logic signed [POSITION_BITS-1:0]      blade_target;
    logic [1:0]                           blade_speed_select;
    logic                                 feed_move;
    logic [wscs_pkg::STEPS_BITS-1:0]      feed_steps;
    logic                                 feed_brake;
    logic                                 home_request;
    logic                                 running;
    logic [wscs_pkg::COUNT_BITS-1:0]      pieces_done;
    logic                                 finished;

    modport source (output valid, output blade_move, output blade_target,
                    output blade_speed_select, output feed_move, output feed_steps,
                    output feed_brake, output home_request, output running,
                    output pieces_done, output finished, input ready);
    modport sink   (input valid, input blade_move, input blade_target,
                    input blade_speed_select, input feed_move, input feed_steps,
                    input feed_brake, input home_request, input running,
                    input pieces_done, input finished, output ready);
endinterface

interface wscs_cfg_if #(parameter int DATA_BITS = 24);
    logic                                 valid;
    logic                                 ready;
    logic [wscs_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [DATA_BITS-1:0]                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/wire_strip_cut_sequencer.sv =====
// Top level of the wire strip-and-cut sequencer: command register, phase
// update with feed multiply, result register. Uses wscs_pkg and wscs_if.
`timescale 1ns / 1ps
//
//  Channel  Modport  Moves per transfer
//  -------  -------  -------------------------------------------------------
//  cmd      sink     operation, homed, blade_ready, feed_ready
//  res      source   blade and feed commands, home request, run status
//  cfg      sink     register index and write data (always ready)
//
//  Each command passes from transfer through the command register, then the
//  phase logic and the 16x16 feed multiply, into the result register. A new
//  command is taken every cycle unless the result is stalled.
//  Reset puts the phase at idle, the done count, configuration and valid flags at zero.
//  A stalled result holds the result register; the command register then
//  holds too, and cmd.ready drops only when both are full.

module wire_strip_cut_sequencer #(
    parameter int POSITION_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    wscs_cmd_if.sink   cmd,
    wscs_res_if.source res,
    wscs_cfg_if.sink   cfg
);

    localparam int MM_W    = wscs_pkg::MM_BITS;
    localparam int CNT_W   = wscs_pkg::COUNT_BITS;
    localparam int STEPS_W = wscs_pkg::STEPS_BITS;

    // Configuration registers
    logic signed [POSITION_BITS-1:0] blade_up_reg;
    logic signed [POSITION_BITS-1:0] blade_partial_reg;
    logic signed [POSITION_BITS-1:0] blade_full_reg;
    logic [MM_W-1:0]                 lead_strip_reg;
    logic [MM_W-1:0]                 tail_strip_reg;
    logic [MM_W-1:0]                 body_length_reg;
    logic [MM_W-1:0]                 steps_per_mm_reg;
    logic [CNT_W-1:0]                pieces_wanted_reg;

    // Command register
    logic       cmd_valid_reg;
    logic [1:0] op_reg;
    logic       homed_reg;
    logic       blade_rdy_reg;
    logic       feed_rdy_reg;

    // Sequencer state
    wscs_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Result register
    logic                            res_valid_reg;
    logic                            blade_move_reg;
    logic signed [POSITION_BITS-1:0] blade_target_reg;
    logic [1:0]                      speed_reg;
    logic                            feed_move_reg;
    logic [STEPS_W-1:0]              feed_steps_reg;
    logic                            brake_reg;
    logic                            home_reg;
    logic                            running_reg;
    logic [CNT_W-1:0]                pieces_done_reg;
    logic                            finished_reg;

    // Step results
    logic                            b_move;
    logic signed [POSITION_BITS-1:0] b_target;
    logic [1:0]                      b_speed;
    logic                            f_move;
    logic [MM_W-1:0]                 f_mm;
    logic                            brake;
    logic                            home;
    logic                            fin;
    logic [CNT_W-1:0]                count_inc;
    logic [STEPS_W-1:0]              feed_product;

    logic step_fire;
    logic cmd_fire;
    logic cfg_fire;

    assign step_fire = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || step_fire;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    // Take configuration writes, truncated to each field's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blade_up_reg      <= '0;
            blade_partial_reg <= '0;
            blade_full_reg    <= '0;
            lead_strip_reg    <= '0;
            tail_strip_reg    <= '0;
            body_length_reg   <= '0;
            steps_per_mm_reg  <= '0;
            pieces_wanted_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                wscs_pkg::REG_BLADE_UP:      blade_up_reg      <= cfg.data[POSITION_BITS-1:0];
                wscs_pkg::REG_BLADE_PARTIAL: blade_partial_reg <= cfg.data[POSITION_BITS-1:0];
                wscs_pkg::REG_BLADE_FULL:    blade_full_reg    <= cfg.data[POSITION_BITS-1:0];
                wscs_pkg::REG_LEAD_STRIP:    lead_strip_reg    <= cfg.data[MM_W-1:0];
                wscs_pkg::REG_TAIL_STRIP:    tail_strip_reg    <= cfg.data[MM_W-1:0];
                wscs_pkg::REG_BODY_LENGTH:   body_length_reg   <= cfg.data[MM_W-1:0];
                wscs_pkg::REG_STEPS_PER_MM:  steps_per_mm_reg  <= cfg.data[MM_W-1:0];
                wscs_pkg::REG_PIECES_WANTED: pieces_wanted_reg <= cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the command until the step logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            op_reg        <= cmd.operation;
            homed_reg     <= cmd.homed;
            blade_rdy_reg <= cmd.blade_ready;
            feed_rdy_reg  <= cmd.feed_ready;
        end
    end

    // Phase update for one command
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        b_move     = 1'b0;
        b_target   = '0;
        b_speed    = wscs_pkg::SPD_TRAVEL;
        f_move     = 1'b0;
        f_mm       = '0;
        brake      = 1'b0;
        home       = 1'b0;
        fin        = 1'b0;
        case (op_reg)
            wscs_pkg::OP_START:
            begin
                if (phase_reg == wscs_pkg::PH_IDLE)
                begin
                    count_next = '0;
                    if (!homed_reg)
                    begin
                        home       = 1'b1;
                        phase_next = wscs_pkg::PH_HOMING;
                    end
                    else
                    begin
                        b_move     = 1'b1;
                        b_target   = blade_up_reg;
                        phase_next = wscs_pkg::PH_PREP;
                    end
                end
            end
            wscs_pkg::OP_STOP:
            begin
                phase_next = wscs_pkg::PH_STOP;
            end
            wscs_pkg::OP_TICK:
            begin
                case (phase_reg)
                    wscs_pkg::PH_IDLE: ;
                    wscs_pkg::PH_HOMING:
                        if (homed_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_up_reg;
                            phase_next = wscs_pkg::PH_PREP;
                        end
                    wscs_pkg::PH_PREP:
                        if (blade_rdy_reg)
                        begin
                            f_move     = 1'b1;
                            f_mm       = lead_strip_reg;
                            phase_next = wscs_pkg::PH_FEED_LEAD;
                        end
                    wscs_pkg::PH_FEED_LEAD:
                        if (feed_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_partial_reg;
                            b_speed    = wscs_pkg::SPD_CUT;
                            phase_next = wscs_pkg::PH_PART_CUT_A;
                        end
                    wscs_pkg::PH_PART_CUT_A:
                        if (blade_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_up_reg;
                            phase_next = wscs_pkg::PH_RAISE_A;
                        end
                    wscs_pkg::PH_RAISE_A:
                        if (blade_rdy_reg)
                        begin
                            f_move     = 1'b1;
                            f_mm       = body_length_reg;
                            phase_next = wscs_pkg::PH_FEED_BODY;
                        end
                    wscs_pkg::PH_FEED_BODY:
                        if (feed_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_partial_reg;
                            b_speed    = wscs_pkg::SPD_CUT;
                            phase_next = wscs_pkg::PH_PART_CUT_B;
                        end
                    wscs_pkg::PH_PART_CUT_B:
                        if (blade_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_up_reg;
                            phase_next = wscs_pkg::PH_RAISE_B;
                        end
                    wscs_pkg::PH_RAISE_B:
                        if (blade_rdy_reg)
                        begin
                            f_move     = 1'b1;
                            f_mm       = tail_strip_reg;
                            phase_next = wscs_pkg::PH_FEED_TAIL;
                        end
                    wscs_pkg::PH_FEED_TAIL:
                        if (feed_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_full_reg;
                            b_speed    = wscs_pkg::SPD_CUT;
                            phase_next = wscs_pkg::PH_FULL_CUT;
                        end
                    wscs_pkg::PH_FULL_CUT:
                        if (blade_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_up_reg;
                            phase_next = wscs_pkg::PH_RAISE_C;
                        end
                    wscs_pkg::PH_RAISE_C:
                        if (blade_rdy_reg)
                        begin
                            b_move     = 1'b1;
                            b_target   = blade_up_reg;
                            phase_next = wscs_pkg::PH_CHECK;
                        end
                    wscs_pkg::PH_CHECK:
                    begin
                        count_next = count_inc;
                        if (count_inc < pieces_wanted_reg)
                        begin
                            phase_next = wscs_pkg::PH_PREP;
                        end
                        else
                        begin
                            phase_next = wscs_pkg::PH_IDLE;
                            fin        = 1'b1;
                        end
                    end
                    wscs_pkg::PH_STOP:
                    begin
                        b_move     = 1'b1;
                        b_target   = blade_up_reg;
                        b_speed    = wscs_pkg::SPD_DEFAULT;
                        brake      = 1'b1;
                        fin        = 1'b1;
                        phase_next = wscs_pkg::PH_IDLE;
                    end
                    default:
                        phase_next = wscs_pkg::PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // Feed distance; f_mm is zero when no feed move is issued
    assign feed_product = STEPS_W'(steps_per_mm_reg) * STEPS_W'(f_mm);

    // Advance state on each consumed command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wscs_pkg::PH_IDLE;
            count_reg <= '0;
        end
        else if (step_fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            blade_move_reg   <= b_move;
            blade_target_reg <= b_target;
            speed_reg        <= b_speed;
            feed_move_reg    <= f_move;
            feed_steps_reg   <= feed_product;
            brake_reg        <= brake;
            home_reg         <= home;
            running_reg      <= (phase_next != wscs_pkg::PH_IDLE);
            pieces_done_reg  <= (phase_next != wscs_pkg::PH_IDLE) ? count_next : '0;
            finished_reg     <= fin;
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.blade_move         = blade_move_reg;
    assign res.blade_target       = blade_target_reg;
    assign res.blade_speed_select = speed_reg;
    assign res.feed_move          = feed_move_reg;
    assign res.feed_steps         = feed_steps_reg;
    assign res.feed_brake         = brake_reg;
    assign res.home_request       = home_reg;
    assign res.running            = running_reg;
    assign res.pieces_done        = pieces_done_reg;
    assign res.finished           = finished_reg;

    // A consumed command always leaves a result waiting
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> res_valid_reg)
        else $error("consumed command left no result");

    // A finished run reports not running and no count
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && finished_reg) |-> (!running_reg && pieces_done_reg == '0))
        else $error("finished result still reports a run");

    // Braking comes only with the raise at default speed
    a_brake_raise: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && brake_reg) |->
            (blade_move_reg && speed_reg == wscs_pkg::SPD_DEFAULT && finished_reg))
        else $error("feed brake without stop raise");

    // Blade and feed moves never share one step
    a_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(blade_move_reg && feed_move_reg))
        else $error("blade and feed moves in one step");

    // A stop command puts the sequencer in the stop phase
    a_stop_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && op_reg == wscs_pkg::OP_STOP) |=> phase_reg == wscs_pkg::PH_STOP)
        else $error("stop did not arm the stop phase");

endmodule
